// ===== rtl/ptl_pkg.sv =====
package ptl_pkg;

	// command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_CHAR  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_ROWS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT = 2'd1;
	localparam logic [7:0] FONT_ROWS_RESET = 8'd12;

	// special characters
	localparam logic [7:0] CH_NORMAL  = 8'h01;
	localparam logic [7:0] CH_DARK    = 8'h02;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// layout constants
	localparam logic [15:0] SPACE_ADVANCE = 16'd3;
	localparam logic [15:0] FIRST_LINE_GAP = 16'd5;
	localparam logic [15:0] LINE_GAP = 16'd1;
	localparam logic [15:0] INDENT_BACK = 16'd50;
	localparam logic [2:0]  NL_SATURATE = 3'd5;
	localparam logic [2:0]  NL_INDENT_AFTER = 3'd4;

	typedef struct packed {
		logic done;
		logic hit;
	} srch_rsp_t;

endpackage

// ===== rtl/ptl_ram.sv =====
module ptl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/ptl_search.sv =====
module ptl_search #(
	parameter int MAX_GLYPHS = 128,
	parameter int CAW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1,
	parameter int LAW = $clog2(MAX_GLYPHS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [7:0]          code,
	input  logic [LAW-1:0]      limit,
	input  logic                wr_en,
	input  logic [CAW-1:0]      wr_addr,
	input  logic [7:0]          wr_code,
	output ptl_pkg::srch_rsp_t  rsp,
	output logic [LAW-1:0]      idx
);

	import ptl_pkg::*;

	logic           busy_q;
	logic [LAW-1:0] k_q;
	logic [LAW-1:0] chk_q;
	logic           chk_valid_q;
	logic [7:0]     code_q;
	logic [LAW-1:0] limit_q;
	logic [7:0]     rd_code;
	logic           in_range;
	logic           rd_en;
	logic           match;
	logic           done;

	// one read issued per cycle, its registered data then compared with the code
	assign in_range = k_q < limit_q;
	assign rd_en    = busy_q && in_range;
	assign match    = chk_valid_q && (rd_code == code_q);
	assign done     = busy_q && (match || !in_range);

	ptl_ram #(.WIDTH(8), .DEPTH(MAX_GLYPHS), .AW(CAW)) u_codes (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_code),
		.re    (rd_en),
		.raddr (k_q[CAW-1:0]),
		.rdata (rd_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			chk_q       <= '0;
			chk_valid_q <= 1'b0;
			code_q      <= '0;
			limit_q     <= '0;
		end else if (start) begin
			busy_q      <= 1'b1;
			k_q         <= '0;
			chk_valid_q <= 1'b0;
			code_q      <= code;
			limit_q     <= limit;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end
			chk_valid_q <= rd_en;
			chk_q       <= k_q;
			if (rd_en) begin
				k_q <= k_q + LAW'(1);
			end
		end
	end

	assign rsp.done = done;
	assign rsp.hit  = match;
	assign idx      = chk_q;

endmodule

// ===== rtl/proportional_text_layout_core.sv =====
// Proportional text layout engine.
// Input channel (in_valid / in_stall) carries one beat per command: start
// string, load glyph entry, or process character. Output channel
// (out_valid / out_stall) returns exactly one result beat per input beat,
// draw high when a glyph blit is issued.
// Configuration (cfg_we / cfg_index / cfg_data) writes font_rows and
// glyph_count; write only while the block is idle.
// Start, load, space, font select, newline and the unused command give
// their result in the cycle after acceptance. A glyph lookup walks the
// code memory one entry per cycle over at most glyph_count entries, count
// clamped to MAX_GLYPHS; a hit then makes two left memory reads, entry k and
// k+1, and presents the result once the output register is free.
// One item is in flight at a time: a new beat is taken only with the block
// idle and the output register empty or emptied on that same edge, so
// immediate commands can follow back to back while out_stall stays low.
// Reset clears cursor, origin, newline count and font selection, sets
// font_rows to 12 and glyph_count to 0; glyph memories are not cleared.
// While out_stall is high the result beat holds and, with the block idle,
// in_stall stays high until that beat is taken.
module proportional_text_layout_core #(
	parameter int MAX_GLYPHS = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     command,
	input  logic [7:0]                     char_code,
	input  logic [7:0]                     entry_index,
	input  logic [14:0]                    entry_left,
	input  logic [15:0]                    start_x,
	input  logic [15:0]                    start_y,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           draw,
	output logic                           dark_font,
	output logic [14:0]                    source_x,
	output logic [15:0]                    glyph_width,
	output logic [15:0]                    dest_x,
	output logic [15:0]                    dest_y,
	output logic [15:0]                    cursor_x,
	input  logic                           cfg_we,
	input  logic [ptl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptl_pkg::CFG_DATA_W-1:0] cfg_data
);

	import ptl_pkg::*;

	localparam int CAW  = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int LAW  = $clog2(MAX_GLYPHS + 1);
	localparam int LIMW = (LAW > 8) ? LAW : 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_LO,
		ST_HI,
		ST_RES
	} state_t;

	state_t state_q;

	// layout state
	logic [15:0] cx_q, cy_q, origin_q;
	logic [2:0]  nl_q;
	logic        dark_q;
	logic [7:0]  font_rows_q, glyph_count_q;

	// glyph lookup
	logic [LAW-1:0] hit_idx_q;
	logic [14:0]    lo_q;
	logic           res_draw_q;
	logic [14:0]    res_src_q;
	logic [15:0]    res_w_q, res_dx_q;

	// output register
	logic        out_valid_q;
	logic        draw_q, dark_out_q;
	logic [14:0] src_out_q;
	logic [15:0] w_out_q, dx_out_q, dy_out_q, cx_out_q;

	logic slot_free, accept, go_search, res_load;
	logic [15:0] cx_n, cy_n, origin_n;
	logic [2:0]  nl_n, nl_inc;
	logic        dark_n;

	logic [LIMW-1:0] eidx_ext, gc_ext;
	logic [LAW-1:0]  limit;
	logic            load_code, load_left;

	srch_rsp_t       srch_rsp;
	logic [LAW-1:0]  srch_idx;

	logic           left_re;
	logic [LAW-1:0] left_raddr;
	logic [14:0]    left_rd;
	logic [15:0]    width_w;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && slot_free);
	assign accept    = in_valid && !in_stall;

	// a new result beat enters the output register
	assign res_load  = ((state_q == ST_IDLE) && accept && !go_search) ||
		((state_q == ST_RES) && slot_free);

	// table writes: the last entry only holds the closing right edge
	assign eidx_ext  = LIMW'(entry_index);
	assign load_code = accept && (command == CMD_LOAD) && (eidx_ext <  LIMW'(MAX_GLYPHS));
	assign load_left = accept && (command == CMD_LOAD) && (eidx_ext <= LIMW'(MAX_GLYPHS));

	// search bound clamps to the table size
	assign gc_ext = LIMW'(glyph_count_q);
	assign limit  = (gc_ext > LIMW'(MAX_GLYPHS)) ? LAW'(MAX_GLYPHS) : gc_ext[LAW-1:0];

	assign nl_inc = (nl_q < NL_SATURATE) ? nl_q + 3'd1 : nl_q;

	// immediate commands
	always_comb begin
		cx_n      = cx_q;
		cy_n      = cy_q;
		origin_n  = origin_q;
		nl_n      = nl_q;
		dark_n    = dark_q;
		go_search = 1'b0;
		case (command)
			CMD_START: begin
				origin_n = start_x;
				cx_n     = start_x;
				cy_n     = start_y;
				nl_n     = 3'd0;
				dark_n   = 1'b0;
			end
			CMD_CHAR: begin
				case (char_code)
					CH_SPACE:  cx_n = cx_q + SPACE_ADVANCE;
					CH_NORMAL: dark_n = 1'b0;
					CH_DARK:   dark_n = 1'b1;
					CH_NEWLINE: begin
						nl_n = nl_inc;
						cy_n = cy_q + {8'd0, font_rows_q} +
							((nl_inc == 3'd1) ? FIRST_LINE_GAP : LINE_GAP);
						cx_n = origin_q - ((nl_inc > NL_INDENT_AFTER) ? INDENT_BACK : 16'd0);
					end
					default: go_search = 1'b1;
				endcase
			end
			default: ;
		endcase
	end

	ptl_search #(.MAX_GLYPHS(MAX_GLYPHS), .CAW(CAW), .LAW(LAW)) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && go_search),
		.code    (char_code),
		.limit   (limit),
		.wr_en   (load_code),
		.wr_addr (eidx_ext[CAW-1:0]),
		.wr_code (char_code),
		.rsp     (srch_rsp),
		.idx     (srch_idx)
	);

	// left edges: read entry k on a hit, then entry k+1
	assign left_re    = ((state_q == ST_SRCH) && srch_rsp.done && srch_rsp.hit) ||
		(state_q == ST_LO);
	assign left_raddr = (state_q == ST_SRCH) ? srch_idx : hit_idx_q + LAW'(1);

	ptl_ram #(.WIDTH(15), .DEPTH(MAX_GLYPHS + 1), .AW(LAW)) u_lefts (
		.clk   (clk),
		.we    (load_left),
		.waddr (eidx_ext[LAW-1:0]),
		.wdata (entry_left),
		.re    (left_re),
		.raddr (left_raddr),
		.rdata (left_rd)
	);

	assign width_w = {1'b0, left_rd} - {1'b0, lo_q} - 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cx_q          <= '0;
			cy_q          <= '0;
			origin_q      <= '0;
			nl_q          <= '0;
			dark_q        <= 1'b0;
			font_rows_q   <= FONT_ROWS_RESET;
			glyph_count_q <= '0;
			hit_idx_q     <= '0;
			lo_q          <= '0;
			res_draw_q    <= 1'b0;
			res_src_q     <= '0;
			res_w_q       <= '0;
			res_dx_q      <= '0;
			out_valid_q   <= 1'b0;
			draw_q        <= 1'b0;
			dark_out_q    <= 1'b0;
			src_out_q     <= '0;
			w_out_q       <= '0;
			dx_out_q      <= '0;
			dy_out_q      <= '0;
			cx_out_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FONT_ROWS:   font_rows_q   <= cfg_data;
					REG_GLYPH_COUNT: glyph_count_q <= cfg_data;
					default: ;
				endcase
			end

			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (go_search) begin
							state_q <= ST_SRCH;
						end else begin
							cx_q        <= cx_n;
							cy_q        <= cy_n;
							origin_q    <= origin_n;
							nl_q        <= nl_n;
							dark_q      <= dark_n;
							draw_q      <= 1'b0;
							dark_out_q  <= dark_n;
							src_out_q   <= '0;
							w_out_q     <= '0;
							dx_out_q    <= '0;
							dy_out_q    <= cy_n;
							cx_out_q    <= cx_n;
						end
					end
				end
				ST_SRCH: begin
					if (srch_rsp.done) begin
						hit_idx_q <= srch_idx;
						if (srch_rsp.hit) begin
							state_q <= ST_LO;
						end else begin
							res_draw_q <= 1'b0;
							res_src_q  <= '0;
							res_w_q    <= '0;
							res_dx_q   <= '0;
							state_q    <= ST_RES;
						end
					end
				end
				ST_LO: begin
					lo_q    <= left_rd;
					state_q <= ST_HI;
				end
				ST_HI: begin
					res_draw_q <= 1'b1;
					res_src_q  <= lo_q;
					res_w_q    <= width_w;
					res_dx_q   <= cx_q;
					cx_q       <= cx_q + width_w;
					state_q    <= ST_RES;
				end
				ST_RES: begin
					if (slot_free) begin
						draw_q      <= res_draw_q;
						dark_out_q  <= dark_q;
						src_out_q   <= res_src_q;
						w_out_q     <= res_w_q;
						dx_out_q    <= res_dx_q;
						dy_out_q    <= cy_q;
						cx_out_q    <= cx_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign draw        = draw_q;
	assign dark_font   = dark_out_q;
	assign source_x    = src_out_q;
	assign glyph_width = w_out_q;
	assign dest_x      = dx_out_q;
	assign dest_y      = dy_out_q;
	assign cursor_x    = cx_out_q;

endmodule

// ===== rtl/ptl_checker.sv =====
module ptl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  command,
	input logic [15:0] start_x,
	input logic [15:0] start_y,
	input logic        out_valid,
	input logic        out_stall,
	input logic        draw,
	input logic        dark_font,
	input logic [14:0] source_x,
	input logic [15:0] glyph_width,
	input logic [15:0] dest_x,
	input logic [15:0] dest_y,
	input logic [15:0] cursor_x
);

	import ptl_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cursor_x) && $stable(dest_y) &&
			$stable(draw) && $stable(glyph_width))
		else $error("result beat changed while stalled");

	// no blit: blit fields are zero
	a_nodraw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !draw |-> source_x == 15'd0 && glyph_width == 16'd0 && dest_x == 16'd0)
		else $error("blit fields set without draw");

	// blit advances cursor by glyph width
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && draw |-> cursor_x == dest_x + glyph_width)
		else $error("cursor not advanced by glyph width");

	// start answers next cycle at the new origin
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command == CMD_START |=>
			out_valid && !draw && !dark_font &&
			cursor_x == $past(start_x) && dest_y == $past(start_y))
		else $error("start result wrong");

endmodule

bind proportional_text_layout_core ptl_checker u_ptl_checker (.*);

// ===== tb/ptl_layout_checker.sv =====
`timescale 1ns / 100ps

module ptl_layout_checker #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [1:0]                     command,
	input  logic [7:0]                     char_code,
	input  logic [7:0]                     entry_index,
	input  logic [14:0]                    entry_left,
	input  logic [15:0]                    start_x,
	input  logic [15:0]                    start_y,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           draw,
	input  logic                           dark_font,
	input  logic [14:0]                    source_x,
	input  logic [15:0]                    glyph_width,
	input  logic [15:0]                    dest_x,
	input  logic [15:0]                    dest_y,
	input  logic [15:0]                    cursor_x,
	input  logic                           cfg_we,
	input  logic [ptl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptl_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatch_count,
	output int                             backlog
);
	import ptl_pkg::*;

	typedef struct packed {
		logic        draw;
		logic        dark;
		logic [14:0] src;
		logic [15:0] width;
		logic [15:0] dx;
		logic [15:0] dy;
		logic [15:0] cx;
	} layout_t;

	layout_t     pending_layouts[$];

	// own copy of the glyph table, pen and registers
	logic [7:0]  code_mem [0:TABLE_DEPTH-1];
	logic [14:0] left_mem [0:TABLE_DEPTH];
	logic [15:0] pen_x;
	logic [15:0] pen_y;
	logic [15:0] origin;
	logic [2:0]  line_breaks;
	logic        dark_sel;
	logic [7:0]  rows_cfg;
	logic [7:0]  count_cfg;

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatch_count < 40) begin
			$display("%0t layout check: %s got %h want %h", $time, what, got, want);
		end
		mismatch_count++;
	endtask

	task automatic lay_out_beat(input logic [1:0] op, input logic [7:0] code,
			input logic [7:0] idx, input logic [14:0] left, input logic [15:0] sx,
			input logic [15:0] sy, output layout_t res);
		int lim;
		int hit_at;
		logic [15:0] w;
		res = '0;
		case (op)
			CMD_START: begin
				origin = sx;
				pen_x = sx;
				pen_y = sy;
				line_breaks = '0;
				dark_sel = 1'b0;
			end
			CMD_LOAD: begin
				if (idx < TABLE_DEPTH) begin
					code_mem[idx] = code;
					left_mem[idx] = left;
				end else if (idx == TABLE_DEPTH) begin
					left_mem[idx] = left;
				end
			end
			CMD_CHAR: begin
				case (code)
					CH_SPACE: pen_x = pen_x + SPACE_ADVANCE;
					CH_NORMAL: dark_sel = 1'b0;
					CH_DARK: dark_sel = 1'b1;
					CH_NEWLINE: begin
						if (line_breaks < NL_SATURATE) line_breaks++;
						pen_y = pen_y + rows_cfg + ((line_breaks == 3'd1) ? FIRST_LINE_GAP : LINE_GAP);
						pen_x = origin;
						if (line_breaks > NL_INDENT_AFTER) pen_x = pen_x - INDENT_BACK;
					end
					default: begin
						// first match wins; the count is clipped to the table size
						lim = (int'(count_cfg) > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_cfg);
						hit_at = -1;
						for (int k = 0; k < lim; k++) begin
							if (hit_at < 0 && code_mem[k] == code) hit_at = k;
						end
						if (hit_at >= 0) begin
							w = {1'b0, left_mem[hit_at + 1]} - {1'b0, left_mem[hit_at]} - 16'd1;
							res.draw = 1'b1;
							res.src = left_mem[hit_at];
							res.width = w;
							res.dx = pen_x;
							pen_x = pen_x + w;
						end
					end
				endcase
			end
			default: ;
		endcase
		res.dark = dark_sel;
		res.dy = pen_y;
		res.cx = pen_x;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		layout_t want;
		if (!arst_n) begin
			pending_layouts.delete();
			pen_x = '0;
			pen_y = '0;
			origin = '0;
			line_breaks = '0;
			dark_sel = 1'b0;
			rows_cfg = FONT_ROWS_RESET;
			count_cfg = '0;
			mismatch_count = 0;
			backlog = 0;
		end else begin
			// results leave before a beat taken on the same edge can be queued
			if (out_valid && !out_stall) begin
				if (pending_layouts.size() == 0) begin
					report_mismatch("result with nothing expected, cursor_x", cursor_x, '0);
				end else begin
					want = pending_layouts.pop_front();
					if (draw !== want.draw)
						report_mismatch("draw", 16'(draw), 16'(want.draw));
					if (dark_font !== want.dark)
						report_mismatch("dark_font", 16'(dark_font), 16'(want.dark));
					if (source_x !== want.src)
						report_mismatch("source_x", 16'(source_x), 16'(want.src));
					if (glyph_width !== want.width) report_mismatch("glyph_width", glyph_width, want.width);
					if (dest_x !== want.dx) report_mismatch("dest_x", dest_x, want.dx);
					if (dest_y !== want.dy) report_mismatch("dest_y", dest_y, want.dy);
					if (cursor_x !== want.cx) report_mismatch("cursor_x", cursor_x, want.cx);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FONT_ROWS: rows_cfg = cfg_data;
					REG_GLYPH_COUNT: count_cfg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				lay_out_beat(command, char_code, entry_index, entry_left, start_x, start_y, want);
				pending_layouts.push_back(want);
			end
			backlog = pending_layouts.size();
		end
	end

endmodule

// ===== tb/tb_proportional_text_layout_core.sv =====
`timescale 1ns / 100ps

module tb_proportional_text_layout_core;
	import ptl_pkg::*;

	localparam int TABLE_DEPTH = 128;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// indexes past the two real registers; writes there must be harmless
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
	// the quiet limit outlasts a full-table miss, the longest stall run and the longest gap
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 150;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 75;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            command;
	logic [7:0]            char_code;
	logic [7:0]            entry_index;
	logic [14:0]           entry_left;
	logic [15:0]           start_x;
	logic [15:0]           start_y;
	logic                  out_valid;
	logic                  out_stall;
	logic                  draw;
	logic                  dark_font;
	logic [14:0]           source_x;
	logic [15:0]           glyph_width;
	logic [15:0]           dest_x;
	logic [15:0]           dest_y;
	logic [15:0]           cursor_x;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatch_count;
	int backlog;

	// stimulus-side view of the table: which entries hold something, and
	// their codes, so lookups hit often and never touch an empty entry
	bit          entry_loaded [0:TABLE_DEPTH];
	logic [7:0]  table_code [0:TABLE_DEPTH-1];
	logic [14:0] left_run;
	int          layout_count;
	int          burst_left;
	int          quiet_cycles;

	proportional_text_layout_core #(
		.MAX_GLYPHS(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.char_code(char_code),
		.entry_index(entry_index),
		.entry_left(entry_left),
		.start_x(start_x),
		.start_y(start_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.draw(draw),
		.dark_font(dark_font),
		.source_x(source_x),
		.glyph_width(glyph_width),
		.dest_x(dest_x),
		.dest_y(dest_y),
		.cursor_x(cursor_x),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ptl_layout_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) layout_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.char_code(char_code),
		.entry_index(entry_index),
		.entry_left(entry_left),
		.start_x(start_x),
		.start_y(start_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.draw(draw),
		.dark_font(dark_font),
		.source_x(source_x),
		.glyph_width(glyph_width),
		.dest_x(dest_x),
		.dest_y(dest_y),
		.cursor_x(cursor_x),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.backlog(backlog)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: any beat on either channel resets the count
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("[proportional_text_layout_core] ERROR");
		$finish;
	end

	// result sink: short and long stall runs, short free runs and long
	// stretches with no back-pressure at all
	initial begin : sink_pattern
		int   len;
		logic level;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					level = 1'b0;
					len = $urandom_range(1, 6);
				end
				4, 5, 6: begin
					level = 1'b1;
					len = $urandom_range(1, 4);
				end
				7: begin
					level = 1'b1;
					len = $urandom_range(10, 24);
				end
				default: begin
					level = 1'b0;
					len = $urandom_range(30, 120);
				end
			endcase
			repeat (len) begin
				@(negedge clk);
				out_stall <= level;
			end
		end
	end

	// One input beat. Called at a falling edge, returns at the falling edge
	// after acceptance. Valid stays high across a burst; between bursts it
	// drops for a gap, so valid never drops and rises in the same step.
	task automatic put_item(input logic [1:0] op, input logic [7:0] code,
			input logic [7:0] idx, input logic [14:0] left, input logic [15:0] sx,
			input logic [15:0] sy);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
		end
		burst_left--;
		command <= op;
		char_code <= code;
		entry_index <= idx;
		entry_left <= left;
		start_x <= sx;
		start_y <= sy;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// unused fields carry noise so every bit toggles
	task automatic start_string(input logic [15:0] sx, input logic [15:0] sy);
		put_item(CMD_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			15'($urandom_range(0, 32767)), sx, sy);
	endtask

	task automatic send_char(input logic [7:0] code);
		put_item(CMD_CHAR, code, 8'($urandom_range(0, 255)), 15'($urandom_range(0, 32767)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
	endtask

	task automatic load_entry(input int idx, input logic [7:0] code, input logic [14:0] left);
		if (idx <= TABLE_DEPTH) entry_loaded[idx] = 1'b1;
		if (idx < TABLE_DEPTH) table_code[idx] = code;
		put_item(CMD_LOAD, code, idx[7:0], left, 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)));
	endtask

	// hold the sender until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (backlog != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// registers only change with the block idle
	task automatic set_layout(input logic [7:0] rows, input logic [7:0] count);
		drain();
		write_reg(REG_FONT_ROWS, rows);
		write_reg(REG_GLYPH_COUNT, count);
		layout_count = int'(count);
	endtask

	initial begin : stimulus
		int         lim;
		int         roll;
		logic [7:0] pick;
		logic [7:0] rows_plan [PHASES];
		logic [7:0] count_plan [PHASES];

		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_START;
		char_code = '0;
		entry_index = '0;
		entry_left = '0;
		start_x = '0;
		start_y = '0;
		cfg_we = 1'b0;
		cfg_index = REG_FONT_ROWS;
		cfg_data = '0;
		burst_left = 0;
		layout_count = 0;
		left_run = '0;
		foreach (entry_loaded[i]) entry_loaded[i] = 1'b0;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset settings (12 rows, empty search range)
		start_string(16'hFFFF, 16'hFFFF);
		send_char(CH_SPACE);                 // x wraps past 16 bits
		send_char(CH_DARK);
		send_char(CH_NORMAL);
		send_char(8'h41);                    // nothing searched: miss
		repeat (6) send_char(CH_NEWLINE);    // first gap, later gaps, pull-back, saturation
		put_item(CMD_UNUSED, 8'hFF, 8'hFF, 15'h7FFF, 16'hFFFF, 16'hFFFF);
		load_entry(0, 8'h41, 15'h0000);
		load_entry(1, 8'h00, 15'h7FFF);
		load_entry(2, 8'h41, 15'd10);        // duplicate code: first one must win
		load_entry(3, 8'hFF, 15'd20);
		load_entry(TABLE_DEPTH, 8'h42, 15'h7FFF); // closing edge only
		load_entry(255, 8'h43, 15'h1234);    // out of range, dropped

		// directed lookups over three entries
		set_layout(8'd12, 8'd3);
		send_char(CH_DARK);
		send_char(8'h41);                    // widest glyph
		send_char(8'h00);                    // code 0 searched; width wraps
		send_char(8'hFF);                    // sits beyond the count: miss
		send_char(8'h42);
		start_string(16'h0000, 16'h0000);

		// settings per phase, extremes of both registers included
		rows_plan = '{8'd1, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd1};
		count_plan = '{8'd1, 8'd8, 8'd128, 8'd200, 8'd0, 8'd0, 8'd255, 8'd0};
		foreach (rows_plan[p]) begin
			if (rows_plan[p] == 8'd0) rows_plan[p] = 8'($urandom_range(1, 255));
		end
		count_plan[5] = 8'($urandom_range(1, 40));
		count_plan[7] = 8'($urandom_range(0, 128));

		for (int p = 0; p < PHASES; p++) begin
			set_layout(rows_plan[p], count_plan[p]);
			if (p == 4) begin
				write_reg(REG_SPARE_LO, 8'($urandom_range(0, 255)));
				write_reg(REG_SPARE_HI, 8'($urandom_range(0, 255)));
			end
			lim = (layout_count > TABLE_DEPTH) ? TABLE_DEPTH : layout_count;

			// fill whatever a lookup can reach, right edge of the last glyph too;
			// lefts mostly climb in small steps like a real font strip
			if (lim > 0) begin
				for (int i = 0; i <= lim; i++) begin
					if (!entry_loaded[i]) begin
						left_run = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
							: left_run + 15'($urandom_range(1, 24));
						load_entry(i, 8'($urandom_range(0, 255)), left_run);
					end
				end
			end

			// mostly text over the loaded font, some reloads, restarts and junk
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				if ($urandom_range(0, 49) == 0) drain();
				roll = $urandom_range(0, 99);
				if (roll < 5) begin
					start_string(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
				end else if (roll < 15) begin
					if ($urandom_range(0, 9) == 0) begin
						load_entry($urandom_range(TABLE_DEPTH + 1, 255), 8'($urandom_range(0, 255)),
							15'($urandom_range(0, 32767)));
					end else begin
						load_entry($urandom_range(0, TABLE_DEPTH), 8'($urandom_range(0, 255)),
							15'($urandom_range(0, 32767)));
					end
				end else if (roll < 18) begin
					put_item(CMD_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						15'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)));
				end else begin
					roll = $urandom_range(0, 99);
					if (roll < 55 && lim > 0) pick = table_code[$urandom_range(0, lim - 1)];
					else if (roll < 65) pick = CH_SPACE;
					else if (roll < 73) pick = CH_NEWLINE;
					else if (roll < 78) pick = CH_NORMAL;
					else if (roll < 83) pick = CH_DARK;
					else pick = 8'($urandom_range(0, 255));
					send_char(pick);
				end
			end
		end

		// everything back, then a window for stray results
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && backlog == 0) begin
			$display("[proportional_text_layout_core] OK");
		end else begin
			$display("[proportional_text_layout_core] ERROR");
		end
		$finish;
	end

endmodule
